// ===== rtl/core/dpb_pkg.sv =====
// Types and constants shared by the depth pixel back-projection unit.
package dpb_pkg;

  localparam int unsigned CountW = 12;
  localparam int unsigned MagW   = 16;
  localparam int unsigned ZW     = 20;
  localparam int unsigned XyW    = 24;
  localparam int unsigned MulAW  = 36;
  localparam int unsigned MulBW  = 24;
  localparam int unsigned ProdW  = 60;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [ZW-1:0]     ZMax     = {ZW{1'b1}};

  typedef enum logic [2:0] {
    REG_DEPTH_SCALE = 3'd0,
    REG_CENTER_COL  = 3'd1,
    REG_CENTER_ROW  = 3'd2,
    REG_INV_FOCAL_X = 3'd3,
    REG_INV_FOCAL_Y = 3'd4,
    REG_IMAGE_WIDTH = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_Z,
    ST_MUL_XA,
    ST_MUL_XB,
    ST_MUL_YA,
    ST_MUL_YB,
    ST_EMIT
  } dpb_state_e;

  typedef struct packed {
    logic [15:0] depth_raw;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } in_item_t;

  typedef struct packed {
    logic signed [XyW-1:0] point_x;
    logic signed [XyW-1:0] point_y;
    logic [ZW-1:0]         point_z;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic [CountW-1:0]     pixel_col;
    logic [CountW-1:0]     pixel_row;
    logic                  frame_last;
  } out_item_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
  } frame_size_t;

  typedef struct packed {
    logic [CountW-1:0] col;
    logic [CountW-1:0] row;
    logic              frame_end;
  } raster_pos_t;

  // Floor of prod / 2^28 with sign, then clamp to the signed output range.
  function automatic logic [XyW-1:0] lateral_finish(input logic [ProdW-1:0] prod,
                                                    input logic neg);
    logic [ProdW:0]      sum;
    logic [ProdW-28:0]   q;
    logic [XyW-1:0]      res;
    sum = {1'b0, prod} + (ProdW+1)'(28'hFFFFFFF);
    if (neg) begin
      q = sum[ProdW:28];
      if (q > (ProdW-27)'(24'h800000)) begin
        res = 24'h800000;
      end else begin
        res = ~q[XyW-1:0] + 24'd1;
      end
    end else begin
      q = {1'b0, prod[ProdW-1:28]};
      if (q > (ProdW-27)'(24'h7FFFFF)) begin
        res = 24'h7FFFFF;
      end else begin
        res = q[XyW-1:0];
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/depth_pixel_backprojection_unit.sv =====
// Top level: pinhole back-projection of a raster depth stream into colored points.
// Each accepted item passes through MUL_Z, MUL_XA, MUL_XB, MUL_YA, MUL_YB and EMIT in order.
// A new item is taken only in IDLE; the single shared multiplier runs five
// products per item (depth scale, then offset times z and times focal reciprocal, x and y).
// A stalled output holds the last step, and the input stalls until the result moves on.
// Reset: asynchronous active low; clears counters and sequencer, loads register defaults.
module depth_pixel_backprojection_unit #(
  parameter int unsigned MaxDim = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dpb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dpb_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import dpb_pkg::*;

  dpb_state_e state_q, state_d;

  logic [31:0] depth_scale_q;
  logic [15:0] center_col_q, center_row_q;
  logic [23:0] inv_fx_q, inv_fy_q;
  frame_size_t size_q;

  in_item_t          item_q;
  logic [CountW-1:0] col_q, row_q;
  logic              last_q;
  logic [MagW-1:0]   mag_x_q, mag_y_q, mag_x_d, mag_y_d;
  logic              neg_x_q, neg_y_q, neg_x_d, neg_y_d;
  logic [ZW-1:0]     z_q, z_sat;
  logic [XyW-1:0]    x_q;

  logic              out_valid_q;
  out_item_t         out_q;

  logic [MulAW-1:0]  op_a;
  logic [MulBW-1:0]  op_b;
  logic [ProdW-1:0]  prod;
  raster_pos_t       pos;

  logic accept, emit, load_z, load_x, mul_en;
  logic [15:0] pos_col16, pos_row16;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_scale_q       <= 32'd858993;
      center_col_q        <= 16'd5098;
      center_row_q        <= 16'd4085;
      inv_fx_q            <= 24'd32433;
      inv_fy_q            <= 24'd32483;
      size_q.image_width  <= 13'd640;
      size_q.image_height <= 13'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DEPTH_SCALE:  depth_scale_q       <= cfg_data_i;
        REG_CENTER_COL:   center_col_q        <= cfg_data_i[15:0];
        REG_CENTER_ROW:   center_row_q        <= cfg_data_i[15:0];
        REG_INV_FOCAL_X:  inv_fx_q            <= cfg_data_i[23:0];
        REG_INV_FOCAL_Y:  inv_fy_q            <= cfg_data_i[23:0];
        REG_IMAGE_WIDTH:  size_q.image_width  <= cfg_data_i[12:0];
        REG_IMAGE_HEIGHT: size_q.image_height <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  dpb_raster_cnt #(
    .MaxDim(MaxDim)
  ) u_raster_cnt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(accept),
    .size_i(size_q),
    .pos_o (pos)
  );

  dpb_mul_unit u_mul_unit (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .op_a_i(op_a),
    .op_b_i(op_b),
    .prod_o(prod)
  );

  assign pos_col16 = {pos.col, 4'b0000};
  assign pos_row16 = {pos.row, 4'b0000};

  always_comb begin
    neg_x_d = pos_col16 < center_col_q;
    neg_y_d = pos_row16 < center_row_q;
    mag_x_d = neg_x_d ? center_col_q - pos_col16 : pos_col16 - center_col_q;
    mag_y_d = neg_y_d ? center_row_q - pos_row16 : pos_row16 - center_row_q;
  end

  assign z_sat = (prod[47:36] != 12'd0) ? ZMax : prod[35:16];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MUL_Z;
      ST_MUL_Z:  state_d = ST_MUL_XA;
      ST_MUL_XA: state_d = ST_MUL_XB;
      ST_MUL_XB: state_d = ST_MUL_YA;
      ST_MUL_YA: state_d = ST_MUL_YB;
      ST_MUL_YB: state_d = ST_EMIT;
      ST_EMIT:   if (!(out_valid_q && out_stall_i)) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    emit       = 1'b0;
    load_z     = 1'b0;
    load_x     = 1'b0;
    mul_en     = 1'b1;
    op_a       = '0;
    op_b       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ST_MUL_Z: begin
        op_a = MulAW'(depth_scale_q);
        op_b = MulBW'(item_q.depth_raw);
      end
      ST_MUL_XA: begin
        load_z = 1'b1;
        op_a   = MulAW'(mag_x_q);
        op_b   = MulBW'(z_sat);
      end
      ST_MUL_XB: begin
        op_a = prod[MulAW-1:0];
        op_b = MulBW'(inv_fx_q);
      end
      ST_MUL_YA: begin
        load_x = 1'b1;
        op_a   = MulAW'(mag_y_q);
        op_b   = MulBW'(z_q);
      end
      ST_MUL_YB: begin
        op_a = prod[MulAW-1:0];
        op_b = MulBW'(inv_fy_q);
      end
      ST_EMIT: begin
        mul_en = 1'b0;
        emit   = !(out_valid_q && out_stall_i);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= in_item_i;
      col_q   <= pos.col;
      row_q   <= pos.row;
      last_q  <= pos.frame_end;
      mag_x_q <= mag_x_d;
      mag_y_q <= mag_y_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
    end
    if (load_z) begin
      z_q <= z_sat;
    end
    if (load_x) begin
      x_q <= lateral_finish(prod, neg_x_q);
    end
    if (emit) begin
      out_q.point_x    <= x_q;
      out_q.point_y    <= lateral_finish(prod, neg_y_q);
      out_q.point_z    <= z_q;
      out_q.out_red    <= item_q.red;
      out_q.out_green  <= item_q.green;
      out_q.out_blue   <= item_q.blue;
      out_q.pixel_col  <= col_q;
      out_q.pixel_row  <= row_q;
      out_q.frame_last <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/dpb_mul_unit.sv =====
// Shared unsigned multiplier with registered product.
module dpb_mul_unit (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [dpb_pkg::MulAW-1:0]   op_a_i,
  input  logic [dpb_pkg::MulBW-1:0]   op_b_i,
  output logic [dpb_pkg::ProdW-1:0]   prod_o
);
  import dpb_pkg::*;

  logic [MulAW+MulBW-1:0] full;
  logic [ProdW-1:0]       prod_d, prod_q;

  assign full   = op_a_i * op_b_i;
  assign prod_d = full[ProdW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/dpb_raster_cnt.sv =====
// Column and row counters that track the raster position of each pixel.
module dpb_raster_cnt #(
  parameter int unsigned MaxDim = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  dpb_pkg::frame_size_t  size_i,
  output dpb_pkg::raster_pos_t  pos_o
);
  import dpb_pkg::*;

  localparam int unsigned DimW = $clog2(MaxDim + 1);

  logic [CountW-1:0] col_q, col_d, row_q, row_d;
  logic [DimW-1:0]   width_eff, height_eff;
  logic              row_end, frame_end;

  always_comb begin
    if (size_i.image_width == 13'd0 || 32'(size_i.image_width) > 32'(MaxDim)) begin
      width_eff = DimW'(MaxDim);
    end else begin
      width_eff = DimW'(size_i.image_width);
    end
    if (size_i.image_height == 13'd0 || 32'(size_i.image_height) > 32'(MaxDim)) begin
      height_eff = DimW'(MaxDim);
    end else begin
      height_eff = DimW'(size_i.image_height);
    end
  end

  assign row_end   = (32'(col_q) + 32'd1 >= 32'(width_eff)) || (col_q == CountMax);
  assign frame_end = row_end &&
                     ((32'(row_q) + 32'd1 >= 32'(height_eff)) || (row_q == CountMax));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + CountW'(1);
      end else begin
        col_d = col_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.col       = col_q;
  assign pos_o.row       = row_q;
  assign pos_o.frame_end = frame_end;

endmodule
